// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg - shared types and constants of the serial frame receiver
// codes for commands and result kinds, the crc-8 byte step and default sizes
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int BUFFER_DEPTH_DEF = 64;
	localparam int MAX_PAYLOAD_DEF  = 60;
	localparam int MAX_RESULTS      = 64;
	localparam int LEN_MIN          = 4;
	localparam int LEN_OVERHEAD     = 3;
	localparam logic [7:0] CRC_POLY = 8'hD5;

	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_DISCARD = 2'd1,
		KIND_PASS    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_FLUSH = 2'd1,
		CMD_PASS  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	// one byte through the crc-8, msb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/sfr_if.sv =====
// ----------------------------------------------------------------------------
// sfr_if - valid/ready channels of the serial frame receiver
// one channel for received beats, one for result beats
// ----------------------------------------------------------------------------
interface sfr_rx_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface sfr_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       last;

	modport source (output valid, output kind, output out_byte, output frame_end,
		output last, input ready);
	modport sink   (input valid, input kind, input out_byte, input frame_end,
		input last, output ready);
endinterface

// ===== sv/serial_frame_resync_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_resync_receiver - resynchronising serial frame receiver
// length-checked, crc-8 protected frames recovered from a raw byte stream
// ----------------------------------------------------------------------------
// usage
//   rx carries one beat per received byte (opcode 0) or a timeout flush
//   (opcode 1); res carries result beats: frame bytes, discarded bytes or
//   passthrough bytes, with frame_end on the final frame byte and last on the
//   final result of each rx beat. cfg_wr_en/cfg_wr_data set passthrough.
// command handling
//   a command waits in a two-entry queue, then the engine runs it. a data
//   byte costs a crc pass per scan attempt, read one byte at a time over
//   the single store read port, and the emission of each discarded or
//   frame byte; a passthrough byte is emitted directly. a worst-case resync
//   repeats the crc attempt for each byte that it drops.
// reset
//   arst_n empties the store and queue, clears passthrough and drops any
//   result beat not yet taken; no clearing pass is needed.
// stalls
//   a held result beat stalls only the engine; the front keeps taking beats
//   until the queue fills, then drops rx.ready.
// ----------------------------------------------------------------------------
module serial_frame_resync_receiver #(
	parameter int BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF,
	parameter int MAX_PAYLOAD  = sfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sfr_rx_if.sink    rx,
	sfr_res_if.source res,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);

	// classified commands from the front into the queue
	logic          push_valid;
	logic          push_ready;
	sfr_pkg::cmd_t push_cmd;

	// commands from the queue into the engine
	logic          pop_valid;
	logic          pop_ready;
	sfr_pkg::cmd_t pop_cmd;

	sfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd)
	);

	sfr_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// engine owns the byte store and the result register
	sfr_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.MAX_PAYLOAD  (MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.res       (res)
	);

endmodule

// ===== sv/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front - accepts received beats and classifies them
// holds the passthrough register and turns each beat into a command
// ----------------------------------------------------------------------------
module sfr_front (
	input  logic          clk,
	input  logic          arst_n,
	sfr_rx_if.sink        rx,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	output logic          push_valid,
	input  logic          push_ready,
	output sfr_pkg::cmd_t push_cmd
);

	logic passthrough_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passthrough_q <= 1'b0;
		end else if (cfg_wr_en) begin
			passthrough_q <= cfg_wr_data;
		end
	end

	// a flush works in either mode
	always_comb begin
		if (rx.opcode) begin
			push_cmd.kind = sfr_pkg::CMD_FLUSH;
		end else if (passthrough_q) begin
			push_cmd.kind = sfr_pkg::CMD_PASS;
		end else begin
			push_cmd.kind = sfr_pkg::CMD_DATA;
		end
		push_cmd.data = rx.data_byte;
	end

	assign push_valid = rx.valid;
	assign rx.ready   = push_ready;

endmodule

// ===== sv/sfr_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_cmd_queue - two-entry command queue
// decouples the front from the back so either can stall
// ----------------------------------------------------------------------------
module sfr_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  sfr_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output sfr_pkg::cmd_t pop_cmd
);

	localparam int DEPTH = 2;

	sfr_pkg::cmd_t entry_q [DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != 2'(DEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back - framing engine of the serial frame receiver
// circular byte store, length check, crc scan, drops and result emission
// ----------------------------------------------------------------------------
module sfr_back #(
	parameter int BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF,
	parameter int MAX_PAYLOAD  = sfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sfr_pkg::cmd_t cmd,
	sfr_res_if.source     res
);

	localparam int PTR_W   = $clog2(BUFFER_DEPTH);
	localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
	localparam int LW      = (CNT_W > 9) ? CNT_W : 9;
	localparam int SUM_W   = ((PTR_W > 8) ? PTR_W : 8) + 1;
	localparam int RCNT_W  = $clog2(sfr_pkg::MAX_RESULTS + 1);
	localparam int LEN_MAX = MAX_PAYLOAD + sfr_pkg::LEN_OVERHEAD;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_PASS   = 14'b00000000000010,
		S_APPEND = 14'b00000000000100,
		S_SCAN   = 14'b00000000001000,
		S_LEN    = 14'b00000000010000,
		S_CRC    = 14'b00000000100000,
		S_CMP    = 14'b00000001000000,
		S_FRM_RD = 14'b00000010000000,
		S_FRM    = 14'b00000100000000,
		S_DROP_RD= 14'b00001000000000,
		S_DROP   = 14'b00010000000000,
		S_FLUSH  = 14'b00100000000000,
		S_POST   = 14'b01000000000000,
		S_FIN    = 14'b10000000000000
	} state_t;

	state_t             state_q;
	logic [7:0]         mem [BUFFER_DEPTH];
	logic [7:0]         rd_data_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   fill_q;
	logic [7:0]         byte_q;
	logic [7:0]         len_q;
	logic [7:0]         idx_q;
	logic [7:0]         crc_q;
	logic               flush_q;
	logic               pend_v_q;
	sfr_pkg::kind_t     pend_kind_q;
	logic [7:0]         pend_byte_q;
	logic               pend_end_q;
	logic               out_v_q;
	sfr_pkg::kind_t     out_kind_q;
	logic [7:0]         out_byte_q;
	logic               out_end_q;
	logic               out_last_q;
	logic [RCNT_W-1:0]  rcnt_q;

	logic [7:0]         rd_idx;
	logic [PTR_W-1:0]   rd_addr;
	logic [PTR_W-1:0]   wr_addr;
	logic               out_free;
	logic               can_emit;
	logic               emit_req;
	sfr_pkg::kind_t     emit_kind;
	logic               emit_end;
	logic               fin_req;
	logic               out_load;
	logic [8:0]         total;
	logic               drop_loud;

	// logical index to physical address, the sum stays below twice the depth
	function automatic logic [PTR_W-1:0] addr_of(input logic [PTR_W-1:0] h,
		input logic [SUM_W-1:0] i);
		logic [SUM_W-1:0] s;
		s = SUM_W'(h) + i;
		if (s >= SUM_W'(BUFFER_DEPTH)) begin
			s = s - SUM_W'(BUFFER_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	assign total     = {1'b0, len_q} + 9'd2;
	assign drop_loud = (fill_q > CNT_W'(1));
	assign out_free  = !out_v_q || res.ready;
	assign can_emit  = !pend_v_q || out_free;
	assign cmd_ready = (state_q == S_IDLE);

	// read address held steady while a state waits on the output
	always_comb begin
		unique case (state_q)
			S_SCAN:          rd_idx = 8'd1;
			S_LEN:           rd_idx = 8'd2;
			S_CRC:           rd_idx = idx_q + 8'd1;
			S_FRM_RD, S_FRM: rd_idx = idx_q;
			default:         rd_idx = 8'd0;
		endcase
	end

	assign rd_addr = addr_of(head_q, SUM_W'(rd_idx));
	assign wr_addr = addr_of(head_q, SUM_W'(fill_q));

	always_ff @(posedge clk) begin
		if (state_q == S_APPEND) begin
			mem[wr_addr] <= byte_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		emit_req  = 1'b0;
		emit_kind = sfr_pkg::KIND_FRAME;
		emit_end  = 1'b0;
		fin_req   = 1'b0;
		unique case (state_q)
			S_PASS: begin
				emit_req  = 1'b1;
				emit_kind = sfr_pkg::KIND_PASS;
			end
			S_FRM: begin
				emit_req = 1'b1;
				emit_end = ({1'b0, idx_q} + 9'd1 == total);
			end
			S_DROP: begin
				emit_req  = drop_loud;
				emit_kind = sfr_pkg::KIND_DISCARD;
			end
			S_FIN: begin
				fin_req = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// pending result moves into the output register this cycle
	assign out_load = pend_v_q && can_emit &&
		((emit_req && rcnt_q < RCNT_W'(sfr_pkg::MAX_RESULTS)) || fin_req);

	// result path: one pending result so the last flag can be set at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			pend_kind_q <= sfr_pkg::KIND_FRAME;
			pend_byte_q <= 8'd0;
			pend_end_q  <= 1'b0;
			out_v_q     <= 1'b0;
			out_kind_q  <= sfr_pkg::KIND_FRAME;
			out_byte_q  <= 8'd0;
			out_end_q   <= 1'b0;
			out_last_q  <= 1'b0;
			rcnt_q      <= '0;
		end else begin
			if (out_v_q && res.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			if (emit_req && can_emit && rcnt_q < RCNT_W'(sfr_pkg::MAX_RESULTS)) begin
				if (pend_v_q) begin
					out_v_q    <= 1'b1;
					out_kind_q <= pend_kind_q;
					out_byte_q <= pend_byte_q;
					out_end_q  <= pend_end_q;
					out_last_q <= 1'b0;
				end
				pend_v_q    <= 1'b1;
				pend_kind_q <= emit_kind;
				pend_byte_q <= (state_q == S_PASS) ? byte_q : rd_data_q;
				pend_end_q  <= emit_end;
				rcnt_q      <= rcnt_q + RCNT_W'(1);
			end
			if (fin_req && can_emit) begin
				if (pend_v_q) begin
					out_v_q    <= 1'b1;
					out_kind_q <= pend_kind_q;
					out_byte_q <= pend_byte_q;
					out_end_q  <= pend_end_q;
					out_last_q <= 1'b1;
				end
				pend_v_q <= 1'b0;
				rcnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			byte_q  <= 8'd0;
			len_q   <= 8'd0;
			idx_q   <= 8'd0;
			crc_q   <= 8'd0;
			flush_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						byte_q <= cmd.data;
						unique case (cmd.kind)
							sfr_pkg::CMD_PASS: state_q <= S_PASS;
							sfr_pkg::CMD_FLUSH: begin
								flush_q <= 1'b1;
								state_q <= S_FLUSH;
							end
							default: state_q <= S_APPEND;
						endcase
					end
				end
				S_PASS: begin
					if (can_emit) begin
						state_q <= S_FIN;
					end
				end
				S_APPEND: begin
					fill_q  <= fill_q + CNT_W'(1);
					flush_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					state_q <= drop_loud ? S_LEN : S_POST;
				end
				S_LEN: begin
					len_q <= rd_data_q;
					if (rd_data_q < 8'(sfr_pkg::LEN_MIN) || LW'(rd_data_q) > LW'(LEN_MAX)) begin
						state_q <= S_DROP_RD;
					end else if (LW'(fill_q) < LW'(rd_data_q) + LW'(2)) begin
						state_q <= S_POST;
					end else begin
						crc_q   <= 8'd0;
						idx_q   <= 8'd2;
						state_q <= S_CRC;
					end
				end
				S_CRC: begin
					crc_q <= sfr_pkg::crc8_byte(crc_q, rd_data_q);
					if (idx_q == len_q) begin
						state_q <= S_CMP;
					end else begin
						idx_q <= idx_q + 8'd1;
					end
				end
				S_CMP: begin
					if (crc_q == rd_data_q) begin
						idx_q   <= 8'd0;
						state_q <= S_FRM_RD;
					end else begin
						state_q <= S_DROP_RD;
					end
				end
				S_FRM_RD: begin
					state_q <= S_FRM;
				end
				S_FRM: begin
					if (can_emit) begin
						if (emit_end) begin
							head_q  <= addr_of(head_q, SUM_W'(total));
							fill_q  <= fill_q - CNT_W'(total);
							state_q <= S_SCAN;
						end else begin
							idx_q   <= idx_q + 8'd1;
							state_q <= S_FRM_RD;
						end
					end
				end
				S_DROP_RD: begin
					state_q <= S_DROP;
				end
				S_DROP: begin
					if (!drop_loud || can_emit) begin
						head_q <= addr_of(head_q, SUM_W'(1));
						fill_q <= fill_q - CNT_W'(1);
						if (!flush_q) begin
							state_q <= S_SCAN;
						end else if (fill_q == CNT_W'(1)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DROP_RD;
						end
					end
				end
				S_FLUSH: begin
					state_q <= (fill_q == '0) ? S_FIN : S_DROP_RD;
				end
				S_POST: begin
					if (fill_q == CNT_W'(BUFFER_DEPTH)) begin
						fill_q <= '0;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid     = out_v_q;
	assign res.kind      = out_kind_q;
	assign res.out_byte  = out_byte_q;
	assign res.frame_end = out_end_q;
	assign res.last      = out_last_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(BUFFER_DEPTH))
		else $error("store fill beyond depth");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q && rcnt_q == '0)
		else $error("result left pending between commands");

	a_frame_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRM |-> LW'(fill_q) >= LW'(total))
		else $error("frame emitted beyond held bytes");

	a_fill_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> fill_q < CNT_W'(BUFFER_DEPTH))
		else $error("store left full after a command");
`endif

endmodule

// ===== tb/sv/serial_frame_resync_receiver_test.sv =====
// ----------------------------------------------------------------------------
// serial_frame_resync_receiver_test - self-checking bench of the frame receiver
// drives received bytes and flushes, predicts the result beats with a model of
// the resync store, and checks each result beat in order
// ----------------------------------------------------------------------------
module serial_frame_resync_receiver_test;
	import sfr_pkg::*;

	localparam int DEPTH     = BUFFER_DEPTH_DEF;
	localparam int MAXPAY    = MAX_PAYLOAD_DEF;
	localparam int IDLE_WAIT = 4000;
	localparam int WD_LIMIT  = 400000;
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct {
		kind_t      kind;
		logic [7:0] value;
		logic       frame_end;
		logic       last;
	} res_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	int   errors = 0;
	int   idle_cycles = 0;
	bit   calm = 1'b0;      // no idling at either side
	bit   hold_off = 1'b0;  // sink stall while an item waits

	sfr_rx_if  rx ();
	sfr_res_if res ();

	serial_frame_resync_receiver u_dut (
		.clk(clk), .arst_n(arst_n), .rx(rx.sink), .res(res.source),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// scoreboard: resync store model and queue of expected result beats
	class frame_scoreboard;
		logic [7:0] store[$];
		bit         pass_mode;
		res_beat_t  pending[$];
		res_beat_t  burst[$];

		function void put(kind_t k, logic [7:0] v, logic fe);
			res_beat_t b;
			b.kind = k; b.value = v; b.frame_end = fe; b.last = 1'b0;
			if (burst.size() < MAX_RESULTS) burst.push_back(b);
		endfunction

		function void drop_front();
			if (store.size() > 1) put(KIND_DISCARD, store[0], 1'b0);
			void'(store.pop_front());
		endfunction

		function logic [7:0] frame_crc(int len);
			logic [7:0] c;
			c = 8'h00;
			for (int i = 2; i <= len; i++) begin
				c ^= store[i];
				for (int k = 0; k < 8; k++) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
			end
			return c;
		endfunction

		function void resync();
			int len;
			forever begin
				if (store.size() <= 1) return;
				len = int'(store[1]);
				if (len < LEN_MIN || len > MAXPAY + LEN_OVERHEAD) begin
					drop_front();
					continue;
				end
				if (store.size() < len + 2) return;
				if (frame_crc(len) == store[len + 1]) begin
					for (int i = 0; i < len + 2; i++) put(KIND_FRAME, store[i], i == len + 1);
					for (int i = 0; i < len + 2; i++) void'(store.pop_front());
				end else begin
					drop_front();
				end
			end
		endfunction

		// note one accepted input beat
		function void note_input(logic op, logic [7:0] d);
			burst.delete();
			if (op == OP_FLUSH) begin
				while (store.size() > 0) drop_front();
			end else if (pass_mode) begin
				put(KIND_PASS, d, 1'b0);
			end else begin
				if (store.size() < DEPTH) store.push_back(d);
				resync();
				if (store.size() >= DEPTH) store.delete();
			end
			if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i]) pending.push_back(burst[i]);
		endfunction

		// check one accepted result beat against the oldest expectation
		task check_result(logic [1:0] k, logic [7:0] v, logic fe, logic l);
			res_beat_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result kind %0d byte %02h", k, v));
				return;
			end
			e = pending.pop_front();
			if (k != e.kind) report($sformatf("kind %0d, want %0d", k, e.kind));
			if (v != e.value) report($sformatf("byte %02h, want %02h", v, e.value));
			if (fe != e.frame_end) report($sformatf("frame_end %0b, want %0b", fe, e.frame_end));
			if (l != e.last) report($sformatf("last %0b, want %0b", l, e.last));
		endtask
	endclass

	frame_scoreboard sb = new();

	// sink side: random stall bursts, sampled at the rising edge
	initial begin
		int stall;
		res.ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) stall--;
			else if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 4);
			res.ready = (stall == 0) && !hold_off;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_result(res.kind, res.out_byte, res.frame_end, res.last);
	end

	// watchdog on cycles with no beat moving on either channel
	always @(posedge clk) begin
		if ((rx.valid && rx.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("serial_frame_resync_receiver_test NOT OK");
			$finish;
		end
	end

	// one input beat, with a random idle burst ahead of it
	task automatic send_beat(input logic op, input logic [7:0] d);
		if (!calm && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		rx.valid = 1'b1;
		rx.opcode = op;
		rx.data_byte = d;
		do @(posedge clk); while (!rx.ready);
		sb.note_input(op, d);
		@(negedge clk);
		rx.valid = 1'b0;
	endtask

	task automatic send_frame(input int len, input bit good);
		logic [7:0] body[$];
		logic [7:0] c;
		body.push_back(8'hC8);
		body.push_back(len[7:0]);
		c = 8'h00;
		for (int i = 0; i < len - 1; i++) begin
			body.push_back(8'($urandom_range(0, 255)));
			c ^= body[body.size() - 1];
			for (int k = 0; k < 8; k++) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		body.push_back(good ? c : ~c);
		foreach (body[i]) send_beat(OP_DATA, body[i]);
	endtask

	// wait for every expected beat, then let the engine settle
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic set_mode(input bit m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.pass_mode = m;
	endtask

	initial begin
		int n, sel, len;
		rx.valid = 1'b0;
		rx.opcode = OP_DATA;
		rx.data_byte = 8'h00;
		sb.pass_mode = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: length extremes, bad crc, out-of-range length, flushes
		set_mode(1'b0);
		send_beat(OP_FLUSH, 8'h00);               // flush of an empty store
		send_frame(LEN_MIN, 1'b1);
		send_beat(OP_DATA, 8'hFF);
		send_beat(OP_DATA, 8'h03);                // length below range
		send_beat(OP_DATA, 8'h40);                // length above range
		send_beat(OP_DATA, 8'h00);
		send_beat(OP_FLUSH, 8'hFF);               // flush of a single held byte
		send_beat(OP_DATA, 8'hAA);
		send_beat(OP_FLUSH, 8'h00);               // flush of the only byte
		send_frame(LEN_MIN, 1'b0);
		send_beat(OP_FLUSH, 8'h00);
		send_frame(MAXPAY + LEN_OVERHEAD, 1'b1);  // longest frame
		set_mode(1'b1);
		send_beat(OP_DATA, 8'h00);
		send_beat(OP_DATA, 8'hFF);
		send_beat(OP_FLUSH, 8'h00);
		set_mode(1'b0);

		// random: mostly well-formed frames with noise between them
		n = 0;
		while (n < 80) begin
			if (n > 60) calm = 1'b1;
			if (n % 40 == 39) set_mode(1'($urandom_range(0, 1)));
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				len = ($urandom_range(0, 5) == 0)
					? int'($urandom_range(LEN_MIN, MAXPAY + LEN_OVERHEAD))
					: int'($urandom_range(LEN_MIN, 10));
				send_frame(len, $urandom_range(0, 4) != 0);
				n += len + 2;
			end else if (sel < 9) begin
				send_beat(OP_DATA, 8'($urandom_range(0, 255)));
				n++;
			end else begin
				// sink hold-off while a flush beat is sent
				if (!calm) hold_off = 1'b1;
				send_beat(OP_FLUSH, 8'($urandom_range(0, 255)));
				hold_off = 1'b0;
				n++;
			end
		end
		// fill the store to overflow with an endless unfinished frame
		set_mode(1'b0);
		send_beat(OP_DATA, 8'h00);
		send_beat(OP_DATA, 8'h3F);
		repeat (DEPTH) send_beat(OP_DATA, 8'($urandom_range(0, 255)));
		send_beat(OP_FLUSH, 8'h00);
		set_mode(1'b0);

		drain();
		if (errors == 0 && sb.pending.size() == 0)
			$display("serial_frame_resync_receiver_test OK");
		else
			$display("serial_frame_resync_receiver_test NOT OK");
		$finish;
	end

endmodule

// ===== serial_frame_resync_receiver.f =====
sv/sfr_pkg.sv
sv/sfr_if.sv
sv/sfr_front.sv
sv/sfr_cmd_queue.sv
sv/sfr_back.sv
sv/serial_frame_resync_receiver.sv
tb/sv/serial_frame_resync_receiver_test.sv
